/* rtl/erc_pkg.sv */
package erc_pkg;

   // Fixed field widths of the request and response channels.
   localparam int EDGE_W = 8;
   localparam int SRC_W  = 4;
   localparam int SEQ_W  = 32;
   localparam int TIME_W = 32;
   localparam int DEC_W  = 3;

   // Default table sizes.
   localparam int NUM_EDGES_DEF    = 256;
   localparam int SOURCE_COUNT_DEF = 16;

   // A sequence number of zero never counts as a valid sequence.
   localparam logic [SEQ_W-1:0] SEQ_NONE = '0;

   typedef enum logic [DEC_W-1:0] {
      DEC_APPLIED   = 3'd0,
      DEC_DOMINATED = 3'd1,
      DEC_DUPLICATE = 3'd2,
      DEC_STALE     = 3'd3,
      DEC_CONFLICT  = 3'd4,
      DEC_INVALID   = 3'd5
   } decision_type;

   // One entry of the per-(source, edge) progress table.
   typedef struct packed {
      logic              valid;
      logic [SEQ_W-1:0]  sequence_num;
      logic [TIME_W-1:0] obs_time;
      logic              blocked;
   } prog_entry_type;

   // One entry of the per-edge winner overlay.
   typedef struct packed {
      logic              valid;
      logic [SRC_W-1:0]  source;
      logic [TIME_W-1:0] obs_time;
      logic              blocked;
   } overlay_entry_type;

   // Fields of one response.
   typedef struct packed {
      decision_type      decision;
      logic [SEQ_W-1:0]  recorded_sequence;
      logic              winner_valid;
      logic [SRC_W-1:0]  winner_source;
      logic [TIME_W-1:0] winner_time;
      logic              winner_blocked;
   } result_type;

   // Write controls from the decision logic to the tables.
   typedef struct packed {
      logic              prog_we;
      prog_entry_type    prog_wdata;
      logic              ovl_we;
      overlay_entry_type ovl_wdata;
   } update_type;

endpackage

/* rtl/erc_ram.sv */
module erc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   parameter int AW    = 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/erc_judge.sv */
module erc_judge (
   input  logic                       invalid,
   input  logic [erc_pkg::SRC_W-1:0]  source_id,
   input  logic [erc_pkg::SEQ_W-1:0]  sequence_req,
   input  logic [erc_pkg::TIME_W-1:0] observed_time,
   input  logic                       blocked,
   input  erc_pkg::prog_entry_type    prog,
   input  erc_pkg::overlay_entry_type ovl,
   output erc_pkg::update_type        upd,
   output erc_pkg::result_type        res
);
   import erc_pkg::*;

   logic              wins;
   logic              dominated;
   overlay_entry_type ovl_after;

   // The event beats the stored winner by newer time, then blocked over open,
   // then the higher source.
   always_comb begin
      if (observed_time != ovl.obs_time) begin
         wins = observed_time > ovl.obs_time;
      end else if (blocked != ovl.blocked) begin
         wins = blocked;
      end else begin
         wins = source_id > ovl.source;
      end
   end

   assign dominated = ovl.valid && (ovl.source != source_id) && !wins;

   always_comb begin
      upd                        = '0;
      upd.prog_wdata.valid        = 1'b1;
      upd.prog_wdata.sequence_num = sequence_req;
      upd.prog_wdata.obs_time     = observed_time;
      upd.prog_wdata.blocked      = blocked;
      upd.ovl_wdata.valid         = 1'b1;
      upd.ovl_wdata.source        = source_id;
      upd.ovl_wdata.obs_time      = observed_time;
      upd.ovl_wdata.blocked       = blocked;
      res                         = '0;

      if (invalid) begin
         res.decision = DEC_INVALID;
      end else if (sequence_req == SEQ_NONE ||
                   (prog.valid && sequence_req < prog.sequence_num)) begin
         res.decision = DEC_STALE;
      end else if (prog.valid && sequence_req == prog.sequence_num) begin
         if (prog.obs_time == observed_time && prog.blocked == blocked) begin
            res.decision = DEC_DUPLICATE;
         end else begin
            res.decision = DEC_CONFLICT;
         end
      end else begin
         upd.prog_we  = 1'b1;
         upd.ovl_we   = !dominated;
         res.decision = dominated ? DEC_DOMINATED : DEC_APPLIED;
      end

      ovl_after = upd.ovl_we ? upd.ovl_wdata : ovl;

      if (!invalid) begin
         if (upd.prog_we) begin
            res.recorded_sequence = sequence_req;
         end else if (prog.valid) begin
            res.recorded_sequence = prog.sequence_num;
         end
         if (ovl_after.valid) begin
            res.winner_valid   = 1'b1;
            res.winner_source  = ovl_after.source;
            res.winner_time    = ovl_after.obs_time;
            res.winner_blocked = ovl_after.blocked;
         end
      end
   end

endmodule

/* rtl/edge_state_reconciler_core.sv */
// Channel   | Ports                                      | Handshake
// ----------+--------------------------------------------+-------------------------------
// request   | req_edge_index .. req_blocked              | taken when start && !busy
// response  | rsp_decision .. rsp_winner_blocked         | rsp_valid for one cycle
//
// For each request, the accept edge reads both tables, and the
// next edge decides, writes the tables back and registers the response. The
// registered read port of the table memories sets this split.
// After reset the block spends EDGE*SOURCE table rows (4096 at the default
// sizes) clearing the tables, one row per cycle, with busy held high.
// The response shows in the cycle after the decision; the receiver cannot stall
// it, and a new request may be taken in the same cycle that a response shows.
module edge_state_reconciler_core #(
   parameter int NUM_EDGES    = erc_pkg::NUM_EDGES_DEF,
   parameter int SOURCE_COUNT = erc_pkg::SOURCE_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [erc_pkg::EDGE_W-1:0] req_edge_index,
   input  logic [erc_pkg::SRC_W-1:0]  req_source_id,
   input  logic [erc_pkg::SEQ_W-1:0]  req_sequence_req,
   input  logic [erc_pkg::TIME_W-1:0] req_observed_time,
   input  logic                       req_blocked,
   output logic                       rsp_valid,
   output logic [erc_pkg::DEC_W-1:0]  rsp_decision,
   output logic [erc_pkg::SEQ_W-1:0]  rsp_recorded_sequence,
   output logic                       rsp_winner_valid,
   output logic [erc_pkg::SRC_W-1:0]  rsp_winner_source,
   output logic [erc_pkg::TIME_W-1:0] rsp_winner_observed_time,
   output logic                       rsp_winner_blocked
);
   import erc_pkg::*;

   // Only edges and sources that the request fields can name need storage.
   localparam int EDGE_LIM   = 1 << EDGE_W;
   localparam int SRC_LIM    = 1 << SRC_W;
   localparam int EDGE_DEPTH = (NUM_EDGES < EDGE_LIM) ? NUM_EDGES : EDGE_LIM;
   localparam int SRC_DEPTH  = (SOURCE_COUNT < SRC_LIM) ? SOURCE_COUNT : SRC_LIM;
   localparam int SLOT_DEPTH = EDGE_DEPTH * SRC_DEPTH;
   localparam int EDGE_AW    = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
   localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int PROG_W     = $bits(prog_entry_type);
   localparam int OVL_W      = $bits(overlay_entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_AW-1:0]   clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff;

   // Captured request, used during the decision cycle.
   logic                 invalid_ff;
   logic [SLOT_AW-1:0]   slot_ff;
   logic [EDGE_AW-1:0]   edge_ff;
   logic [SRC_W-1:0]     src_ff;
   logic [SEQ_W-1:0]     seq_ff;
   logic [TIME_W-1:0]    time_ff;
   logic                 blocked_ff;

   logic                 accept;
   logic                 in_range;
   logic [SLOT_AW-1:0]   slot_raddr;
   logic [EDGE_AW-1:0]   edge_raddr;

   logic                 prog_we;
   logic [SLOT_AW-1:0]   prog_waddr;
   logic [PROG_W-1:0]    prog_wdata;
   logic [PROG_W-1:0]    prog_rdata;
   logic                 ovl_we;
   logic [EDGE_AW-1:0]   ovl_waddr;
   logic [OVL_W-1:0]     ovl_wdata;
   logic [OVL_W-1:0]     ovl_rdata;

   update_type           upd;
   result_type           res;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Edges or sources past the configured counts are rejected without writing
   // either table; their read address is parked at zero.
   assign in_range = (32'(req_edge_index) < NUM_EDGES) &&
                     (32'(req_source_id) < SOURCE_COUNT);
   assign slot_raddr = in_range ?
      SLOT_AW'(32'(req_edge_index) * SRC_DEPTH + 32'(req_source_id)) : '0;
   assign edge_raddr = in_range ? EDGE_AW'(req_edge_index) : '0;

   // The tables are read on every cycle; only the read at the accept edge is
   // used. The write of a decision lands before the next request can be read,
   // so back-to-back requests to one entry never see stale data.
   erc_ram #(.WIDTH(PROG_W), .DEPTH(SLOT_DEPTH), .AW(SLOT_AW)) u_prog_ram (
      .clock (clock),
      .we    (prog_we),
      .waddr (prog_waddr),
      .wdata (prog_wdata),
      .raddr (slot_raddr),
      .rdata (prog_rdata)
   );

   erc_ram #(.WIDTH(OVL_W), .DEPTH(EDGE_DEPTH), .AW(EDGE_AW)) u_ovl_ram (
      .clock (clock),
      .we    (ovl_we),
      .waddr (ovl_waddr),
      .wdata (ovl_wdata),
      .raddr (edge_raddr),
      .rdata (ovl_rdata)
   );

   erc_judge u_judge (
      .invalid       (invalid_ff),
      .source_id     (src_ff),
      .sequence_req  (seq_ff),
      .observed_time (time_ff),
      .blocked       (blocked_ff),
      .prog          (prog_entry_type'(prog_rdata)),
      .ovl           (overlay_entry_type'(ovl_rdata)),
      .upd           (upd),
      .res           (res)
   );

   // Write port steering: the clearing pass zeroes rows after reset, and the
   // decision cycle writes back what the judge asks for.
   always_comb begin
      prog_we    = 1'b0;
      prog_waddr = slot_ff;
      prog_wdata = PROG_W'(upd.prog_wdata);
      ovl_we     = 1'b0;
      ovl_waddr  = edge_ff;
      ovl_wdata  = OVL_W'(upd.ovl_wdata);
      unique case (state_ff)
         ST_CLEAR: begin
            prog_we    = 1'b1;
            prog_waddr = clr_ff;
            prog_wdata = '0;
            ovl_we     = (32'(clr_ff) < EDGE_DEPTH);
            ovl_waddr  = clr_ff[EDGE_AW-1:0];
            ovl_wdata  = '0;
         end
         ST_LOOK: begin
            prog_we = upd.prog_we;
            ovl_we  = upd.ovl_we;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_AW'(SLOT_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         invalid_ff <= !in_range;
         slot_ff    <= slot_raddr;
         edge_ff    <= edge_raddr;
         src_ff     <= req_source_id;
         seq_ff     <= req_sequence_req;
         time_ff    <= req_observed_time;
         blocked_ff <= req_blocked;
      end
      if (state_ff == ST_LOOK) begin
         result_ff <= res;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_decision             = result_ff.decision;
   assign rsp_recorded_sequence    = result_ff.recorded_sequence;
   assign rsp_winner_valid         = result_ff.winner_valid;
   assign rsp_winner_source        = result_ff.winner_source;
   assign rsp_winner_observed_time = result_ff.winner_time;
   assign rsp_winner_blocked       = result_ff.winner_blocked;

   // A response always follows a decision cycle.
   a_rsp_after_look: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_LOOK))
      else $error("response without a decision cycle");

   // An accepted request is decided in the next cycle.
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOK))
      else $error("accepted request not decided");

   // Nothing is answered while the tables are being cleared.
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid)
      else $error("response during clearing pass");

   // A rejected request never writes either table.
   a_invalid_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && invalid_ff) |-> (!prog_we && !ovl_we))
      else $error("table write for an out-of-range request");

endmodule
